[rtl/core/csvft_pkg.sv]
// csvft_pkg: shared types, constants and helpers of the csv field tokenizer
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package csvft_pkg;

    localparam int SPACE_HOLD_DEPTH = 16;
    localparam int HOLD_CNT_W = $clog2(SPACE_HOLD_DEPTH + 1);
    localparam int HOLD_IDX_W = (SPACE_HOLD_DEPTH > 1) ? $clog2(SPACE_HOLD_DEPTH) : 1;

    localparam int BYTE_W = 8;
    localparam int CFG_IDX_W = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] DELIMITER_RESET = 8'h2C;
    localparam logic [BYTE_W-1:0] QUALIFIER_RESET = 8'h22;

    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUALIFIER = 8'd1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_EMIT       = 2'd1,
        OP_END_FIELD  = 2'd2,
        OP_END_RECORD = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        QM_OUTSIDE = 3'b001,
        QM_INSIDE  = 3'b010,
        QM_PENDING = 3'b100
    } quote_mode_t;

    function automatic logic is_ws(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

[rtl/core/csvft_in_if.sv]
// csvft_in_if: input byte channel of the csv field tokenizer
// depends on csvft_pkg for the byte width
`default_nettype none

interface csvft_in_if;
    logic                          valid;
    logic                          ready;
    logic [csvft_pkg::BYTE_W-1:0]  in_byte;
    logic                          end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

[rtl/core/csvft_out_if.sv]
// csvft_out_if: result channel of the csv field tokenizer
// depends on csvft_pkg for the byte width
`default_nettype none

interface csvft_out_if;
    logic                          valid;
    logic                          ready;
    logic [csvft_pkg::BYTE_W-1:0]  out_byte;
    logic                          byte_valid;
    logic                          field_end;
    logic                          record_end;
    logic                          space_dropped;
    logic                          last_of_run;

    modport source (
        output valid, output out_byte, output byte_valid, output field_end,
        output record_end, output space_dropped, output last_of_run, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input field_end,
        input record_end, input space_dropped, input last_of_run, output ready
    );
endinterface

`default_nettype wire

[rtl/core/csvft_cfg_if.sv]
// csvft_cfg_if: register write channel of the csv field tokenizer
// depends on csvft_pkg for index and data widths
`default_nettype none

interface csvft_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csvft_pkg::CFG_IDX_W-1:0] index;
    logic [csvft_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/csvft_front.sv]
// csvft_front: accepts text bytes, tracks quoting and field start, issues commands
// depends on csvft_pkg and the input and config interfaces
`default_nettype none

module csvft_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    csvft_in_if.sink            rx,
    csvft_cfg_if.sink           cfg,
    input  wire logic           q_full,
    output csvft_pkg::cmd_t     push_cmd,
    output logic                push
);

    logic [csvft_pkg::BYTE_W-1:0] delim_reg;
    logic [csvft_pkg::BYTE_W-1:0] qual_reg;
    csvft_pkg::quote_mode_t       mode_reg, mode_next;
    logic                         seen_reg, seen_next;
    csvft_pkg::quote_mode_t       mode_eff;
    logic                         accept;
    logic                         do_content;
    logic [csvft_pkg::BYTE_W-1:0] c;

    assign rx.ready  = !q_full;
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign c         = rx.in_byte;

    always_comb
    begin
        mode_next     = mode_reg;
        seen_next     = seen_reg;
        push          = 1'b0;
        push_cmd.op   = csvft_pkg::OP_EMIT;
        push_cmd.data = c;
        do_content    = 1'b0;
        // a pending qualifier leaves quotes unless it is doubled
        mode_eff      = (mode_reg == csvft_pkg::QM_PENDING) ? csvft_pkg::QM_OUTSIDE
                                                            : mode_reg;
        if (rx.end_of_input)
        begin
            push        = 1'b1;
            push_cmd.op = csvft_pkg::OP_END_RECORD;
            mode_next   = csvft_pkg::QM_OUTSIDE;
            seen_next   = 1'b0;
        end
        else if (mode_reg == csvft_pkg::QM_PENDING && c == qual_reg)
        begin
            mode_next  = csvft_pkg::QM_INSIDE;
            do_content = 1'b1;
        end
        else
        begin
            mode_next = mode_eff;
            if (c == qual_reg)
            begin
                mode_next = (mode_eff == csvft_pkg::QM_INSIDE) ? csvft_pkg::QM_PENDING
                                                               : csvft_pkg::QM_INSIDE;
            end
            else if (mode_eff != csvft_pkg::QM_INSIDE && c == csvft_pkg::NEWLINE_CODE)
            begin
                push        = 1'b1;
                push_cmd.op = csvft_pkg::OP_END_RECORD;
                seen_next   = 1'b0;
            end
            else if (mode_eff != csvft_pkg::QM_INSIDE && c == delim_reg)
            begin
                push        = 1'b1;
                push_cmd.op = csvft_pkg::OP_END_FIELD;
                seen_next   = 1'b0;
            end
            else
            begin
                do_content = 1'b1;
            end
        end

        if (do_content)
        begin
            if (csvft_pkg::is_ws(c))
            begin
                // leading whitespace of a field is dropped here
                push        = seen_reg;
                push_cmd.op = csvft_pkg::OP_HOLD;
            end
            else
            begin
                push        = 1'b1;
                push_cmd.op = csvft_pkg::OP_EMIT;
                seen_next   = 1'b1;
            end
        end

        if (!accept)
        begin
            push      = 1'b0;
            mode_next = mode_reg;
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= csvft_pkg::QM_OUTSIDE;
            seen_reg  <= 1'b0;
            delim_reg <= csvft_pkg::DELIMITER_RESET;
            qual_reg  <= csvft_pkg::QUALIFIER_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    csvft_pkg::REG_DELIMITER: delim_reg <= cfg.data;
                    csvft_pkg::REG_QUALIFIER: qual_reg  <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/csvft_queue.sv]
// csvft_queue: short command fifo between the front and back parts
// depends on csvft_pkg for the command type and depth
`default_nettype none

module csvft_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire csvft_pkg::cmd_t  push_cmd,
    input  wire logic             pop,
    output csvft_pkg::cmd_t       head,
    output logic                  full,
    output logic                  empty
);

    csvft_pkg::cmd_t                  mem [csvft_pkg::QUEUE_DEPTH];
    logic [csvft_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [csvft_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [csvft_pkg::QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (cnt_reg == csvft_pkg::QUEUE_CNT_W'(csvft_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // pointers wrap naturally at a power-of-two depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/csvft_back.sv]
// csvft_back: holds inner whitespace and drives results into the output register
// depends on csvft_pkg and the output interface
`default_nettype none

module csvft_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire csvft_pkg::cmd_t  head,
    input  wire logic             empty,
    output logic                  pop,
    csvft_out_if.source           tx
);

    logic [csvft_pkg::BYTE_W-1:0]     held [csvft_pkg::SPACE_HOLD_DEPTH];
    logic [csvft_pkg::HOLD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [csvft_pkg::HOLD_CNT_W-1:0] idx_reg, idx_next;
    logic                             ovf_reg, ovf_next;
    logic                             hold_we;

    logic                         valid_reg, valid_next;
    logic [csvft_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                         bv_reg, bv_next;
    logic                         fe_reg, fe_next;
    logic                         re_reg, re_next;
    logic                         sd_reg, sd_next;
    logic                         last_reg, last_next;
    logic                         adv;
    logic                         load;

    assign adv = !valid_reg || tx.ready;

    always_comb
    begin
        pop        = 1'b0;
        hold_we    = 1'b0;
        load       = 1'b0;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ovf_next   = ovf_reg;
        byte_next  = byte_reg;
        bv_next    = bv_reg;
        fe_next    = fe_reg;
        re_next    = re_reg;
        sd_next    = sd_reg;
        last_next  = last_reg;
        if (!empty)
        begin
            case (head.op)
                csvft_pkg::OP_HOLD:
                begin
                    pop = 1'b1;
                    if (cnt_reg < csvft_pkg::HOLD_CNT_W'(csvft_pkg::SPACE_HOLD_DEPTH))
                    begin
                        hold_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                csvft_pkg::OP_EMIT:
                begin
                    if (adv)
                    begin
                        load    = 1'b1;
                        bv_next = 1'b1;
                        fe_next = 1'b0;
                        re_next = 1'b0;
                        sd_next = ovf_reg;
                        // replay held run a byte per adv cycle, then content byte
                        if (idx_reg < cnt_reg)
                        begin
                            byte_next = held[idx_reg[csvft_pkg::HOLD_IDX_W-1:0]];
                            last_next = 1'b0;
                            idx_next  = idx_reg + 1'b1;
                        end
                        else
                        begin
                            byte_next = head.data;
                            last_next = 1'b1;
                            pop       = 1'b1;
                            cnt_next  = '0;
                            idx_next  = '0;
                            ovf_next  = 1'b0;
                        end
                    end
                end
                csvft_pkg::OP_END_FIELD, csvft_pkg::OP_END_RECORD:
                begin
                    if (adv)
                    begin
                        load      = 1'b1;
                        pop       = 1'b1;
                        byte_next = '0;
                        bv_next   = 1'b0;
                        fe_next   = 1'b1;
                        re_next   = (head.op == csvft_pkg::OP_END_RECORD);
                        sd_next   = 1'b0;
                        last_next = 1'b1;
                        // trailing whitespace is trimmed silently
                        cnt_next  = '0;
                        idx_next  = '0;
                        ovf_next  = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        valid_next = load || (valid_reg && !tx.ready);
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
            held[cnt_reg[csvft_pkg::HOLD_IDX_W-1:0]] <= head.data;
        if (load)
        begin
            byte_reg <= byte_next;
            bv_reg   <= bv_next;
            fe_reg   <= fe_next;
            re_reg   <= re_next;
            sd_reg   <= sd_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign tx.valid         = valid_reg;
    assign tx.out_byte      = byte_reg;
    assign tx.byte_valid    = bv_reg;
    assign tx.field_end     = fe_reg;
    assign tx.record_end    = re_reg;
    assign tx.space_dropped = sd_reg;
    assign tx.last_of_run   = last_reg;

endmodule

`default_nettype wire

[rtl/core/csv_field_tokenizer_unit.sv]
// csv_field_tokenizer_unit: top level of the csv field tokenizer
// depends on csvft_pkg, the three channel interfaces, csvft_front, csvft_queue, csvft_back
//
// usage
//   rx carries one text byte (or an end_of_input mark) per transfer; tx carries one
//   result per transfer: a content byte, or a field end / record end mark.
//   cfg writes delimiter_char (index 0) and qualifier_char (index 1); cfg is always
//   ready and must only be written while the block is idle.
// timing
//   the front takes one byte per cycle while the 4-entry command queue has room.
//   quote bytes, other than a doubled qualifier, and leading whitespace produce no
//   result; inner whitespace is held in a 16-entry store.
//   a content byte releases the held whitespace run before it, one result per held
//   byte, and then itself; a field end gives one result.
//   a result passes through the command queue and the output register before tx.
// reset
//   rst_n clears quoting state, the queue, the hold count and the output valid flag;
//   delimiter and qualifier return to ',' and '"'.
// stalls
//   when tx is not ready the output register holds its result, the back part takes
//   only whitespace holds, the queue fills, and rx ready drops once the queue is full.
`default_nettype none

module csv_field_tokenizer_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    csvft_in_if.sink     rx,
    csvft_out_if.source  tx,
    csvft_cfg_if.sink    cfg
);

    csvft_pkg::cmd_t push_cmd;
    csvft_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    csvft_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .q_full   (q_full),
        .push_cmd (push_cmd),
        .push     (push)
    );

    csvft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    csvft_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (q_empty),
        .pop   (pop),
        .tx    (tx)
    );

endmodule

`default_nettype wire

[verif/csv_field_tokenizer_unit_tb.sv]
// csv_field_tokenizer_unit_tb: self-checking bench for the csv field tokenizer
// drives text bytes and register writes, predicts every token and compares it
// depends on csvft_pkg, the csvft channel interfaces and csv_field_tokenizer_unit
`default_nettype none

module csv_field_tokenizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RANDOM_PER_PHASE = 40;
    localparam int NUM_PHASES       = 9;

    typedef struct packed {
        logic [7:0] data;
        logic       bv;
        logic       fe;
        logic       re;
        logic       sd;
        logic       last;
    } token_t;

    typedef struct {
        logic [7:0] b;
        logic       eoi;
        bit         typed;
        int         n;
        token_t     tok;
    } script_row_t;

    localparam token_t FIELD_MARK  = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    localparam token_t RECORD_MARK = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam token_t NO_TOKEN    = '0;

    // default delimiter and qualifier throughout
    script_row_t script [0:23] = '{
        '{8'h5A, 1'b1, 1'b1, 1, RECORD_MARK},                          // end of input at once
        '{8'h61, 1'b0, 1'b1, 1, '{8'h61, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, 1'b1, 1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'h2C, 1'b0, 1'b1, 1, FIELD_MARK},
        '{8'h00, 1'b0, 1'b1, 1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'h20, 1'b0, 1'b1, 0, NO_TOKEN},                             // inner space held
        '{8'h09, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h62, 1'b0, 1'b0, 0, NO_TOKEN},                             // releases the held run
        '{8'h22, 1'b0, 1'b1, 0, NO_TOKEN},
        '{8'h2C, 1'b0, 1'b0, 0, NO_TOKEN},                             // delimiter inside quotes
        '{8'h0A, 1'b0, 1'b0, 0, NO_TOKEN},                             // newline inside quotes
        '{8'h22, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, 0, NO_TOKEN},                             // doubled qualifier
        '{8'h22, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h78, 1'b0, 1'b0, 0, NO_TOKEN},                             // leaves quotes
        '{8'h0A, 1'b0, 1'b1, 1, RECORD_MARK},
        '{8'h0A, 1'b0, 1'b1, 1, RECORD_MARK},                          // empty record
        '{8'h20, 1'b0, 1'b1, 0, NO_TOKEN},                             // leading space dropped
        '{8'h71, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b1, 0, NO_TOKEN},                             // opens quotes mid-field
        '{8'h2C, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h22, 1'b0, 1'b0, 0, NO_TOKEN},
        '{8'h00, 1'b1, 1'b1, 1, RECORD_MARK}                           // open quote closed
    };

    logic clk;
    logic rst_n;

    csvft_in_if  rx_if ();
    csvft_out_if tx_if ();
    csvft_cfg_if cfg_if ();

    csv_field_tokenizer_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if),
        .cfg   (cfg_if)
    );

    // tokenizer image
    logic [7:0]             cfg_delim;
    logic [7:0]             cfg_qual;
    csvft_pkg::quote_mode_t qstate;
    bit                     seen_content;
    logic [7:0]             held_ws [csvft_pkg::SPACE_HOLD_DEPTH];
    int                     held_n;
    bit                     spill;

    token_t step_tokens [$];
    token_t expected_tokens [$];

    int errors = 0;
    int bytes_sent = 0;
    int tokens_checked = 0;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    function automatic bit is_blank(input logic [7:0] c);
        return c inside {8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};
    endfunction

    function automatic void add_token(input logic [7:0] d, input logic bv, input logic fe,
                                      input logic re, input logic sd);
        step_tokens.push_back('{d, bv, fe, re, sd, 1'b0});
    endfunction

    function automatic void close_field(input logic rec);
        add_token(8'h00, 1'b0, 1'b1, rec, 1'b0);
        seen_content = 0;
        held_n = 0;
        spill = 0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        if (is_blank(c))
        begin
            if (!seen_content)
                return;
            if (held_n < csvft_pkg::SPACE_HOLD_DEPTH)
            begin
                held_ws[held_n] = c;
                held_n++;
            end
            else
                spill = 1;
            return;
        end
        for (int i = 0; i < held_n; i++)
            add_token(held_ws[i], 1'b1, 1'b0, 1'b0, spill);
        add_token(c, 1'b1, 1'b0, 1'b0, spill);
        held_n = 0;
        spill = 0;
        seen_content = 1;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eoi);
        step_tokens.delete();
        if (eoi)
        begin
            close_field(1'b1);
            qstate = csvft_pkg::QM_OUTSIDE;
        end
        else if (qstate == csvft_pkg::QM_PENDING && c == cfg_qual)
        begin
            qstate = csvft_pkg::QM_INSIDE;
            take_char(c);
        end
        else
        begin
            if (qstate == csvft_pkg::QM_PENDING)
                qstate = csvft_pkg::QM_OUTSIDE;
            if (c == cfg_qual)
                qstate = (qstate == csvft_pkg::QM_INSIDE) ? csvft_pkg::QM_PENDING
                                                          : csvft_pkg::QM_INSIDE;
            else if (qstate != csvft_pkg::QM_INSIDE && c == csvft_pkg::NEWLINE_CODE)
                close_field(1'b1);
            else if (qstate != csvft_pkg::QM_INSIDE && c == cfg_delim)
                close_field(1'b0);
            else
                take_char(c);
        end
        if (step_tokens.size() > 0)
            step_tokens[$].last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_blank();
        logic [7:0] opts [5] = '{8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h20};
        return opts[$urandom_range(4)];
    endfunction

    // biased toward the bytes that steer the parse
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'($urandom_range(33, 126));
        else if (r < 48)
            return pick_blank();
        else if (r < 61)
            return cfg_delim;
        else if (r < 75)
            return cfg_qual;
        else if (r < 84)
            return csvft_pkg::NEWLINE_CODE;
        else
            return 8'($urandom_range(255));
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic transfer_byte(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_if.valid <= 1'b0;
            @(posedge clk);
        end
        rx_if.valid        <= 1'b1;
        rx_if.in_byte      <= b;
        rx_if.end_of_input <= eoi;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        transfer_byte(b, eoi);
        predict_tokens(b, eoi);
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endtask

    // lowers valid in the step of the last transfer, then lets the block go quiet
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_codes(input logic [7:0] d, input logic [7:0] q);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= csvft_pkg::REG_DELIMITER;
        cfg_if.data  <= d;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_delim = d;
        cfg_if.index <= csvft_pkg::REG_QUALIFIER;
        cfg_if.data  <= q;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_qual = q;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, compare each transfer with the oldest expectation
    initial
    begin
        token_t got;
        token_t want;
        tx_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (tx_if.valid && tx_if.ready)
            begin
                got = '{tx_if.out_byte, tx_if.byte_valid, tx_if.field_end,
                        tx_if.record_end, tx_if.space_dropped, tx_if.last_of_run};
                tokens_checked++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected result: out_byte %02h field_end %0b record_end %0b",
                           got.data, got.fe, got.re);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, got.data);
                        errors++;
                    end
                    if (got.bv !== want.bv)
                    begin
                        $error("byte_valid: expected %0b, got %0b", want.bv, got.bv);
                        errors++;
                    end
                    if (got.fe !== want.fe)
                    begin
                        $error("field_end: expected %0b, got %0b", want.fe, got.fe);
                        errors++;
                    end
                    if (got.re !== want.re)
                    begin
                        $error("record_end: expected %0b, got %0b", want.re, got.re);
                        errors++;
                    end
                    if (got.sd !== want.sd)
                    begin
                        $error("space_dropped: expected %0b, got %0b", want.sd, got.sd);
                        errors++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                        errors++;
                    end
                end
            end
            tx_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ends the run once no channel has moved for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int i;
        int k;
        int r;
        bit paused;
        logic [7:0] d;
        logic [7:0] q;

        rst_n              <= 1'b0;
        rx_if.valid        <= 1'b0;
        rx_if.in_byte      <= 8'h00;
        rx_if.end_of_input <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= csvft_pkg::REG_DELIMITER;
        cfg_if.data        <= 8'h00;

        cfg_delim    = csvft_pkg::DELIMITER_RESET;
        cfg_qual     = csvft_pkg::QUALIFIER_RESET;
        qstate       = csvft_pkg::QM_OUTSIDE;
        seen_content = 0;
        held_n       = 0;
        spill        = 0;
        paused       = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[j])
        begin
            transfer_byte(script[j].b, script[j].eoi);
            predict_tokens(script[j].b, script[j].eoi);
            if (script[j].typed)
            begin
                if (script[j].n > 0)
                    expected_tokens.push_back(script[j].tok);
            end
            else
                foreach (step_tokens[m])
                    expected_tokens.push_back(step_tokens[m]);
        end

        // hold store: overflow reported, exact depth clean, overflow trimmed at field end
        send_byte(8'h6B, 1'b0);
        repeat (csvft_pkg::SPACE_HOLD_DEPTH + 2) send_byte(pick_blank(), 1'b0);
        send_byte(8'h7A, 1'b0);
        repeat (csvft_pkg::SPACE_HOLD_DEPTH + 4) send_byte(pick_blank(), 1'b0);
        send_byte(8'h2C, 1'b0);
        send_byte(8'h6D, 1'b0);
        repeat (csvft_pkg::SPACE_HOLD_DEPTH) send_byte(pick_blank(), 1'b0);
        send_byte(8'h6E, 1'b0);
        repeat (csvft_pkg::SPACE_HOLD_DEPTH + 1) send_byte(pick_blank(), 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin d = 8'h2C; q = 8'h22; end
                1: begin d = csvft_pkg::NEWLINE_CODE; q = 8'h27; end  // delimiter doubles as newline
                2: begin d = 8'h00; q = 8'hFF; end
                3: begin d = 8'hFF; q = 8'h00; end
                4: begin d = 8'h09; q = 8'h20; end          // whitespace qualifier
                5: begin d = 8'h7C; q = 8'h7C; end          // qualifier wins over delimiter
                6: begin d = 8'h2C; q = csvft_pkg::NEWLINE_CODE; end
                7: begin d = 8'($urandom_range(255)); q = 8'($urandom_range(255)); end
                default:
                begin
                    d = csvft_pkg::DELIMITER_RESET;
                    q = csvft_pkg::QUALIFIER_RESET;
                end
            endcase
            set_codes(d, q);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
                default: begin src_idle_pct = 14; snk_stall_pct = 14; end
            endcase
            i = 0;
            while (i < RANDOM_PER_PHASE)
            begin
                r = $urandom_range(99);
                if (r >= 94)
                begin
                    k = $urandom_range(12, csvft_pkg::SPACE_HOLD_DEPTH + 4);
                    repeat (k) send_byte(pick_blank(), 1'b0);
                    i += k;
                end
                else if (r >= 89)
                begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                    i++;
                end
                else
                begin
                    send_byte(pick_byte(), 1'b0);
                    i++;
                end
                if (p == 2 && i >= RANDOM_PER_PHASE / 2 && !paused)
                begin
                    // sender holds off until every result is back
                    drain();
                    paused = 1;
                end
            end
            drain();
        end

        if (expected_tokens.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_tokens.size());
            errors++;
        end
        $display("summary: %0d input transfers, %0d results compared, %0d code settings",
                 bytes_sent, tokens_checked, NUM_PHASES);
        $display("summary: quoting, hold overflow and delimiter/qualifier corner codes");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/csvft_pkg.sv
rtl/core/csvft_in_if.sv
rtl/core/csvft_out_if.sv
rtl/core/csvft_cfg_if.sv
rtl/core/csvft_front.sv
rtl/core/csvft_queue.sv
rtl/core/csvft_back.sv
rtl/core/csv_field_tokenizer_unit.sv
verif/csv_field_tokenizer_unit_tb.sv
